/* rtl/core/iaee_pkg.sv */
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Shared types, character codes, operator and status codes for the evaluator
// and its iterative multiply/divide unit.
// ----------------------------------------------------------------------------
package iaee_pkg;

   // Width of the decimal number accumulator and of the multiplier operand.
   localparam int NUM_WIDTH = 32;

   // ASCII codes of the characters the evaluator reacts to.
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // Pending multiplicative operator.
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_MUL  = 2'd1;
   localparam logic [1:0] OP_DIV  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_RUN,
      ST_FIX,
      ST_POST,
      ST_EMIT
   } state_type;

   // What remains to be done for the beat being processed.
   typedef enum logic [2:0] {
      ACT_MUL,
      ACT_DIV,
      ACT_ADD,
      ACT_SUB,
      ACT_END
   } action_type;

   // Command from the sequencer to the shift-add unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } unit_cmd_type;

endpackage

/* rtl/core/iaee_shift_add_unit.sv */
// ----------------------------------------------------------------------------
// Shift-add multiply/divide unit
// One shared adder serves an unsigned shift-add multiply (one multiplier bit
// per cycle) and a restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module iaee_shift_add_unit import iaee_pkg::*; #(
   parameter int VALUE_WIDTH = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  unit_cmd_type                      cmd,
   input  logic [VALUE_WIDTH-1:0]            opa,
   input  logic [NUM_WIDTH-1:0]              opb,
   output logic                              done,
   output logic [VALUE_WIDTH+NUM_WIDTH-1:0]  product,
   output logic [VALUE_WIDTH-1:0]            quotient
);

   localparam int AW = VALUE_WIDTH + 2;
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] sh_ff, sh_in;
   logic [VALUE_WIDTH-1:0] opnd_ff, opnd_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   div_ff, div_in;
   logic                   done_ff, done_in;

   logic [AW-1:0] add_a;
   logic [AW-1:0] add_b;
   logic [AW-1:0] add_sum;
   logic          no_borrow;

   // Shared adder: accumulate for multiply, trial subtract for divide.
   always_comb begin
      if (div_ff) begin
         add_a = AW'({acc_ff[NUM_WIDTH-1:0], sh_ff[VALUE_WIDTH-1]});
         add_b = AW'(opnd_ff);
      end else begin
         add_a = AW'(acc_ff);
         add_b = sh_ff[0] ? AW'(opnd_ff) : '0;
      end
      add_sum   = add_a + (add_b ^ {AW{div_ff}}) + AW'(div_ff);
      no_borrow = ~add_sum[AW-1];
   end

   // Load on start, then one step per cycle until the count runs out.
   always_comb begin
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opnd_in = opnd_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         acc_in = '0;
         div_in = cmd.is_div;
         if (cmd.is_div) begin
            sh_in   = opa;
            opnd_in = VALUE_WIDTH'(opb);
            cnt_in  = CW'(VALUE_WIDTH);
         end else begin
            sh_in   = VALUE_WIDTH'(opb);
            opnd_in = opa;
            cnt_in  = CW'(NUM_WIDTH);
         end
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
         if (div_ff) begin
            if (no_borrow) begin
               acc_in = VALUE_WIDTH'(add_sum[NUM_WIDTH-1:0]);
               sh_in  = {sh_ff[VALUE_WIDTH-2:0], 1'b1};
            end else begin
               acc_in = VALUE_WIDTH'({acc_ff[NUM_WIDTH-2:0], sh_ff[VALUE_WIDTH-1]});
               sh_in  = {sh_ff[VALUE_WIDTH-2:0], 1'b0};
            end
         end else begin
            acc_in = add_sum[VALUE_WIDTH:1];
            sh_in  = {add_sum[0], sh_ff[VALUE_WIDTH-1:1]};
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         div_ff  <= div_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      opnd_ff <= opnd_in;
   end

   assign done     = done_ff;
   assign product  = {acc_ff, sh_ff[VALUE_WIDTH-1 -: NUM_WIDTH]};
   assign quotient = sh_ff;

endmodule

/* rtl/core/infix_add_mul_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// Infix expression evaluator, four operators
// Reads an infix expression one character per beat and returns its value,
// signed fixed point, with status, after the beat marked end of line.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                  Direction
//   --------  -------------------------------------  ---------
//   req       req_valid/ready, char_code, end_of_line  in
//   rsp       rsp_valid/ready, value, status           out
//
// A digit, space or other character does not close the number. An operator adds
// a number close; a pending '*', or '/' by a nonzero number, runs the shift-add
// unit one bit per cycle. The end of line adds one more close and a step to load
// the result register. Synchronous active-high reset clears all state but the
// result payload and the unit datapath. The input is not ready while a close
// runs, nor while a finished line waits for an unread result.
// ----------------------------------------------------------------------------
module infix_add_mul_expression_evaluator import iaee_pkg::*; #(
   parameter int VALUE_WIDTH = 48,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_char_code,
   input  logic                          req_end_of_line,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_value,
   output logic [1:0]                    rsp_status
);

   localparam int VW       = VALUE_WIDTH;
   localparam int AW       = VALUE_WIDTH + 2;
   localparam int INT_BITS = VALUE_WIDTH - 1 - FRAC_BITS;
   localparam logic [VW-1:0] POS_LIMIT = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] NEG_LIMIT = {1'b1, {(VW-1){1'b0}}};

   state_type  state_ff, state_in;
   action_type act_ff, act_in;
   logic       eol_ff, eol_in;
   logic [VW-1:0]        sum_ff, sum_in;
   logic [VW-1:0]        term_ff, term_in;
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [1:0]           op_ff, op_in;
   logic                 sign_ff, sign_in;
   logic [1:0]           err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_value_ff, rsp_value_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   unit_cmd_type                 unit_cmd;
   logic                         unit_done;
   logic [VW+NUM_WIDTH-1:0]      unit_product;
   logic [VW-1:0]                unit_quotient;

   // Character decode and decimal digit accumulation.
   logic                 is_digit;
   logic [7:0]           digit_off;
   logic [NUM_WIDTH+3:0] num_ext;
   logic [NUM_WIDTH+3:0] num_next;
   logic                 num_ovf;

   always_comb begin
      is_digit  = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
      digit_off = req_char_code - CHAR_ZERO;
      num_ext   = (NUM_WIDTH+4)'(num_ff);
      num_next  = (num_ext << 3) + (num_ext << 1) + (NUM_WIDTH+4)'(digit_off[3:0]);
      num_ovf   = |num_next[NUM_WIDTH+3:NUM_WIDTH];
   end

   // Closing a number: integer to fixed point, and the term magnitude.
   logic [63:0]   n_wide;
   logic          n_ovf;
   logic [VW-1:0] n_fixed;
   logic          term_neg;
   logic [VW-1:0] term_mag;

   always_comb begin
      n_wide   = 64'(num_ff);
      n_ovf    = (n_wide >> INT_BITS) != 64'd0;
      n_fixed  = n_ovf ? POS_LIMIT : VW'(n_wide << FRAC_BITS);
      term_neg = term_ff[VW-1];
      term_mag = term_neg ? -term_ff : term_ff;
   end

   // Product clamp and sign for the finished multiply or divide.
   logic          mul_ovf;
   logic [VW-1:0] mul_mag;
   logic [VW-1:0] mul_term;
   logic [VW-1:0] div_term;

   always_comb begin
      if (term_neg) begin
         mul_ovf = (|unit_product[VW+NUM_WIDTH-1:VW]) ||
                   (unit_product[VW-1] && (|unit_product[VW-2:0]));
      end else begin
         mul_ovf = |unit_product[VW+NUM_WIDTH-1:VW-1];
      end
      mul_mag  = mul_ovf ? (term_neg ? NEG_LIMIT : POS_LIMIT) : unit_product[VW-1:0];
      mul_term = term_neg ? -mul_mag : mul_mag;
      div_term = term_neg ? -unit_quotient : unit_quotient;
   end

   // Saturating add or subtract of the term into the running sum.
   logic [AW-1:0] sat_raw;
   logic [2:0]    sat_top;
   logic          sat_ovf;
   logic [VW-1:0] sat_sum;

   always_comb begin
      sat_raw = {{2{sum_ff[VW-1]}}, sum_ff} +
                ({{2{term_ff[VW-1]}}, term_ff} ^ {AW{sign_ff}}) + AW'(sign_ff);
      sat_top = sat_raw[AW-1:VW-1];
      sat_ovf = !((sat_top == 3'b000) || (sat_top == 3'b111));
      sat_sum = sat_ovf ? (sat_raw[AW-1] ? NEG_LIMIT : POS_LIMIT) : sat_raw[VW-1:0];
   end

   // Iterative multiply/divide unit.
   iaee_shift_add_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (unit_cmd),
      .opa      (term_mag),
      .opb      (num_ff),
      .done     (unit_done),
      .product  (unit_product),
      .quotient (unit_quotient)
   );

   // Sequencer: next state, datapath updates and handshakes.
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      eol_in        = eol_ff;
      sum_in        = sum_ff;
      term_in       = term_ff;
      num_in        = num_ff;
      op_in         = op_ff;
      sign_in       = sign_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unit_cmd      = '0;
      req_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               eol_in = req_end_of_line;
               if (is_digit) begin
                  if (num_ovf) begin
                     num_in = '1;
                     if (err_ff == STATUS_OK) begin
                        err_in = STATUS_OVERFLOW;
                     end
                  end else begin
                     num_in = num_next[NUM_WIDTH-1:0];
                  end
                  act_in   = ACT_END;
                  state_in = req_end_of_line ? ST_CLOSE : ST_IDLE;
               end else if (req_char_code == CHAR_STAR) begin
                  act_in   = ACT_MUL;
                  state_in = ST_CLOSE;
               end else if (req_char_code == CHAR_SLASH) begin
                  act_in   = ACT_DIV;
                  state_in = ST_CLOSE;
               end else if (req_char_code == CHAR_PLUS) begin
                  act_in   = ACT_ADD;
                  state_in = ST_CLOSE;
               end else if (req_char_code == CHAR_MINUS) begin
                  act_in   = ACT_SUB;
                  state_in = ST_CLOSE;
               end else begin
                  act_in   = ACT_END;
                  state_in = req_end_of_line ? ST_CLOSE : ST_IDLE;
               end
            end
         end

         ST_CLOSE: begin
            num_in = '0;
            if (n_ovf && (err_ff == STATUS_OK)) begin
               err_in = STATUS_OVERFLOW;
            end
            case (op_ff)
               OP_MUL: begin
                  unit_cmd.start  = 1'b1;
                  unit_cmd.is_div = 1'b0;
                  state_in        = ST_RUN;
               end
               OP_DIV: begin
                  if (num_ff == '0) begin
                     term_in = '0;
                     if (err_ff == STATUS_OK) begin
                        err_in = STATUS_DIV_ZERO;
                     end
                     state_in = ST_POST;
                  end else begin
                     unit_cmd.start  = 1'b1;
                     unit_cmd.is_div = 1'b1;
                     state_in        = ST_RUN;
                  end
               end
               default: begin
                  term_in  = n_fixed;
                  state_in = ST_POST;
               end
            endcase
         end

         ST_RUN: begin
            if (unit_done) begin
               state_in = ST_FIX;
            end
         end

         ST_FIX: begin
            if (op_ff == OP_MUL) begin
               term_in = mul_term;
               if (mul_ovf && (err_ff == STATUS_OK)) begin
                  err_in = STATUS_OVERFLOW;
               end
            end else begin
               term_in = div_term;
            end
            state_in = ST_POST;
         end

         ST_POST: begin
            case (act_ff)
               ACT_MUL, ACT_DIV: begin
                  op_in = (act_ff == ACT_MUL) ? OP_MUL : OP_DIV;
                  if (eol_ff) begin
                     act_in   = ACT_END;
                     state_in = ST_CLOSE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               ACT_ADD, ACT_SUB: begin
                  sum_in  = sat_sum;
                  term_in = '0;
                  sign_in = (act_ff == ACT_SUB);
                  op_in   = OP_NONE;
                  if (sat_ovf && (err_ff == STATUS_OK)) begin
                     err_in = STATUS_OVERFLOW;
                  end
                  if (eol_ff) begin
                     act_in   = ACT_END;
                     state_in = ST_CLOSE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               ACT_END: begin
                  sum_in = sat_sum;
                  if (sat_ovf && (err_ff == STATUS_OK)) begin
                     err_in = STATUS_OVERFLOW;
                  end
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_EMIT: begin
            // Load the result once the output register is free, then start over.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (err_ff == STATUS_DIV_ZERO) ? '0 : sum_ff;
               rsp_status_in = err_ff;
               sum_in        = '0;
               term_in       = '0;
               num_in        = '0;
               op_in         = OP_NONE;
               sign_in       = 1'b0;
               err_in        = STATUS_OK;
               eol_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and expression state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_ff       <= ACT_END;
         eol_ff       <= 1'b0;
         sum_ff       <= '0;
         term_ff      <= '0;
         num_ff       <= '0;
         op_ff        <= OP_NONE;
         sign_ff      <= 1'b0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         eol_ff       <= eol_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         num_ff       <= num_in;
         op_ff        <= op_in;
         sign_ff      <= sign_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* rtl/core/iaee_checker.sv */
// ----------------------------------------------------------------------------
// Infix expression evaluator checker
// Port-level assertions on the evaluator, attached by a bind statement.
// ----------------------------------------------------------------------------
module iaee_checker import iaee_pkg::*; #(
   parameter int VALUE_WIDTH = 48
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [7:0]                    req_char_code,
   input logic                          req_end_of_line,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [VALUE_WIDTH-1:0] rsp_value,
   input logic [1:0]                    rsp_status
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // Division by zero always reports a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_DIV_ZERO) |-> rsp_value == '0)
      else $error("division by zero with nonzero value");

   // Only defined status codes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_OVERFLOW)
      else $error("undefined status code");

   // A beat without end of line never produces a result right after it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_end_of_line && !rsp_valid |=> !rsp_valid)
      else $error("result without end of line");

   // An operator closes the number, so the input stalls on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      ((req_char_code == CHAR_STAR) || (req_char_code == CHAR_SLASH) ||
       (req_char_code == CHAR_PLUS) || (req_char_code == CHAR_MINUS)) |=> !req_ready)
      else $error("input ready right after an operator");

endmodule

bind infix_add_mul_expression_evaluator iaee_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_iaee_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_char_code   (req_char_code),
   .req_end_of_line (req_end_of_line),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_value       (rsp_value),
   .rsp_status      (rsp_status)
);
